>>> hw/rtl/trial_division_prime_test_defines.svh
// Assertion macros shared by the trial division prime test modules.
// Assertions compile out when SYNTHESIS is defined.
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked on every rising edge while reset is released.
`define TDPT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define TDPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TDPT_ASSERT(lbl, clk, rst_n, prop, msg)
`define TDPT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> hw/rtl/tdpt_pkg.sv
`timescale 1ns / 1ps

package tdpt_pkg;

    // Width of the candidate and value fields on the ports.
    localparam int FIELD_BITS = 32;
    // Default working width of the test.
    localparam int VALUE_BITS_DEF = 32;

    typedef struct packed {
        logic [FIELD_BITS-1:0] candidate;
        logic                  last_in;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_BITS-1:0] value;
        logic                  is_prime;
        logic                  last_out;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_EVAL,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture a new candidate and start dividing by 3
        logic div_step;  // one shift-subtract step of the divider
        logic next_d;    // advance the divisor by 2 and restart the divider
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic below_two;
        logic is_two;
        logic is_even;
        logic div_last;
        logic d_above_q;
        logic rem_zero;
    } t_dp_sts;

endpackage

>>> hw/rtl/trial_division_prime_test.sv
`timescale 1ns / 1ps
`include "trial_division_prime_test_defines.svh"
// Trial division prime test. Each input item carries one candidate and a
// last marker; each produces exactly one output item with the candidate
// echoed, a prime flag and the marker copied. Both channels use valid and
// stall: an item moves on a rising edge with valid high and stall low.
// Candidates are reduced to their low VALUE_BITS bits (at most 32).
// Zero, one and even numbers other than two are settled in the cycle
// after acceptance. Odd candidates are divided by the odd numbers from 3 up
// until a divisor leaves no remainder or exceeds the quotient. Each
// trial runs one pass of the shared shift-subtract divider, and an odd
// candidate needs up to about sqrt(candidate) / 2 trials, the most for
// the largest 32-bit primes. One candidate is worked on at a time.
// The result lands in an output register; while the receiver stalls, that
// item holds and the block can still accept and test the next candidate,
// which then waits in its final state until the register frees.
// Synchronous reset empties the output register and idles the controller.
module trial_division_prime_test #(
    parameter int VALUE_BITS = tdpt_pkg::VALUE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tdpt_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tdpt_pkg::t_out_item o_out_item
);

    localparam int WORK_BITS = (VALUE_BITS < tdpt_pkg::FIELD_BITS) ?
                               VALUE_BITS : tdpt_pkg::FIELD_BITS;

    tdpt_pkg::t_dp_cmd    dp_cmd;
    tdpt_pkg::t_dp_sts    dp_sts;
    logic [WORK_BITS-1:0] dp_value;
    logic                 dp_last;
    logic                 ctl_finish;
    logic                 ctl_verdict;
    logic                 out_free;

    logic                 r_out_valid;
    tdpt_pkg::t_out_item  r_out_item;

    // The output register can take a new item when it is empty or when its
    // current item leaves on this edge.
    assign out_free = !r_out_valid || !i_out_stall;

    tdpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_out_free (out_free),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd),
        .o_finish   (ctl_finish),
        .o_verdict  (ctl_verdict)
    );

    tdpt_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_item (i_in_item),
        .i_cmd     (dp_cmd),
        .o_sts     (dp_sts),
        .o_value   (dp_value),
        .o_last    (dp_last)
    );

    // Output register: valid is control state and resets, the item does not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl_finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl_finish) begin
            r_out_item.value    <= tdpt_pkg::FIELD_BITS'(dp_value);
            r_out_item.is_prime <= ctl_verdict;
            r_out_item.last_out <= dp_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A finished item is only handed over when the output register is free,
    // so a waiting result is never overwritten.
    `TDPT_ASSERT(a_finish_free, i_clk, i_rst_n, ctl_finish |-> (!r_out_valid || !i_out_stall), "result overwrote a waiting item")

endmodule

>>> hw/rtl/tdpt_datapath.sv
`timescale 1ns / 1ps
`include "trial_division_prime_test_defines.svh"

module tdpt_datapath #(
    parameter int VALUE_BITS = tdpt_pkg::VALUE_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  tdpt_pkg::t_in_item                      i_in_item,
    input  tdpt_pkg::t_dp_cmd                       i_cmd,
    output tdpt_pkg::t_dp_sts                       o_sts,
    output logic [((VALUE_BITS < tdpt_pkg::FIELD_BITS) ?
                   VALUE_BITS : tdpt_pkg::FIELD_BITS)-1:0] o_value,
    output logic                                    o_last
);

    localparam int WORK_BITS = (VALUE_BITS < tdpt_pkg::FIELD_BITS) ?
                               VALUE_BITS : tdpt_pkg::FIELD_BITS;
    localparam int CNT_BITS  = $clog2(WORK_BITS);

    logic [WORK_BITS-1:0] r_n;
    logic                 r_last;
    logic [WORK_BITS-1:0] r_d;
    logic [WORK_BITS-1:0] r_q;
    logic [WORK_BITS-1:0] r_rem;
    logic [CNT_BITS-1:0]  r_cnt;

    logic [WORK_BITS:0]   dv_trial;
    logic [WORK_BITS:0]   dv_diff;
    logic                 dv_fits;

    // Restoring division: the dividend shifts out of r_q one bit per step
    // while the quotient bits shift in behind it.
    always_comb begin
        dv_trial = {r_rem, r_q[WORK_BITS-1]};
        dv_diff  = dv_trial - {1'b0, r_d};
        dv_fits  = (dv_trial >= {1'b0, r_d});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n    <= i_in_item.candidate[WORK_BITS-1:0];
            r_last <= i_in_item.last_in;
            r_d    <= WORK_BITS'(3);
            r_q    <= i_in_item.candidate[WORK_BITS-1:0];
            r_rem  <= '0;
            r_cnt  <= CNT_BITS'(WORK_BITS - 1);
        end else if (i_cmd.next_d) begin
            r_d    <= r_d + WORK_BITS'(2);
            r_q    <= r_n;
            r_rem  <= '0;
            r_cnt  <= CNT_BITS'(WORK_BITS - 1);
        end else if (i_cmd.div_step) begin
            r_q    <= {r_q[WORK_BITS-2:0], dv_fits};
            r_rem  <= dv_fits ? dv_diff[WORK_BITS-1:0] : dv_trial[WORK_BITS-1:0];
            r_cnt  <= r_cnt - CNT_BITS'(1);
        end
    end

    always_comb begin
        o_sts.below_two = (r_n[WORK_BITS-1:1] == '0);
        o_sts.is_two    = (r_n == WORK_BITS'(2));
        o_sts.is_even   = !r_n[0];
        o_sts.div_last  = (r_cnt == '0);
        o_sts.d_above_q = (r_d > r_q);
        o_sts.rem_zero  = (r_rem == '0);
    end

    assign o_value = r_n;
    assign o_last  = r_last;

    // The partial remainder always stays below the divisor.
    `TDPT_ASSERT(a_rem_below_d, i_clk, i_rst_n, $past(i_cmd.div_step) |-> (r_rem < r_d), "partial remainder reached the divisor")

    // Trial divisors are odd, so a step never runs with an even divisor.
    `TDPT_ASSERT(a_d_odd, i_clk, i_rst_n, i_cmd.div_step |-> r_d[0], "divider stepped with an even divisor")

endmodule

>>> hw/rtl/tdpt_ctrl.sv
`timescale 1ns / 1ps
`include "trial_division_prime_test_defines.svh"

module tdpt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_out_free,
    input  tdpt_pkg::t_dp_sts i_sts,
    output tdpt_pkg::t_dp_cmd o_cmd,
    output logic              o_finish,
    output logic              o_verdict
);

    tdpt_pkg::t_state r_state;
    tdpt_pkg::t_state n_state;
    logic             r_verdict;
    logic             n_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tdpt_pkg::ST_IDLE;
            r_verdict <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_verdict <= n_verdict;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_verdict  = r_verdict;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        o_finish   = 1'b0;
        case (r_state)
            tdpt_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = tdpt_pkg::ST_CHECK;
                end
            end
            tdpt_pkg::ST_CHECK: begin
                if (i_sts.below_two) begin
                    n_verdict = 1'b0;
                    n_state   = tdpt_pkg::ST_DONE;
                end else if (i_sts.is_two) begin
                    n_verdict = 1'b1;
                    n_state   = tdpt_pkg::ST_DONE;
                end else if (i_sts.is_even) begin
                    n_verdict = 1'b0;
                    n_state   = tdpt_pkg::ST_DONE;
                end else begin
                    n_state = tdpt_pkg::ST_DIV;
                end
            end
            tdpt_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = tdpt_pkg::ST_EVAL;
                end
            end
            tdpt_pkg::ST_EVAL: begin
                if (i_sts.d_above_q) begin
                    n_verdict = 1'b1;
                    n_state   = tdpt_pkg::ST_DONE;
                end else if (i_sts.rem_zero) begin
                    n_verdict = 1'b0;
                    n_state   = tdpt_pkg::ST_DONE;
                end else begin
                    o_cmd.next_d = 1'b1;
                    n_state      = tdpt_pkg::ST_DIV;
                end
            end
            tdpt_pkg::ST_DONE: begin
                if (i_out_free) begin
                    o_finish = 1'b1;
                    n_state  = tdpt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tdpt_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_verdict = r_verdict;

    // An accepted item always goes to the special-case check next.
    `TDPT_ASSERT(a_load_to_check, i_clk, i_rst_n, o_cmd.load |=> (r_state == tdpt_pkg::ST_CHECK), "accepted item skipped the check")

    // Divider commands never overlap.
    `TDPT_ASSERT_ALWAYS(a_cmd_onehot, i_clk, $onehot0({o_cmd.load, o_cmd.div_step, o_cmd.next_d}), "overlapping datapath commands")

endmodule

>>> tb/trial_division_prime_test_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the prime tester, predicts one result per
// accepted candidate and compares each delivered result with the oldest
// prediction.
module trial_division_prime_test_checker #(
    parameter int VALUE_BITS = tdpt_pkg::VALUE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  tdpt_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  tdpt_pkg::t_out_item i_out_item,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_results,
    output int                  o_primes
);

    tdpt_pkg::t_out_item expected_verdicts[$];
    tdpt_pkg::t_out_item oldest_verdict;

    function automatic logic prime_by_trial_division(longint unsigned n);
        longint unsigned d;
        if (n < 2) return 1'b0;
        if (n == 2) return 1'b1;
        if (n[0] == 1'b0) return 1'b0;
        for (d = 3; d <= n / d; d += 2) begin
            if (n % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic tdpt_pkg::t_out_item verdict_for(tdpt_pkg::t_in_item item);
        tdpt_pkg::t_out_item verdict;
        longint unsigned     working_mask;
        longint unsigned     n;
        working_mask = {64{1'b1}} >> (64 - VALUE_BITS);
        n = item.candidate;
        n = n & working_mask;
        verdict.value = tdpt_pkg::FIELD_BITS'(n);
        verdict.is_prime = prime_by_trial_division(n);
        verdict.last_out = item.last_in;
        return verdict;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_verdicts.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                expected_verdicts = {expected_verdicts, verdict_for(i_in_item)};
            end
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (i_out_item.is_prime) o_primes++;
                if (expected_verdicts.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result %h arrived with nothing outstanding",
                             $time, i_out_item);
                end else begin
                    oldest_verdict = expected_verdicts.pop_front();
                    if (i_out_item.value !== oldest_verdict.value) begin
                        o_fail_count++;
                        $display("%0t: value expected %h, got %h", $time,
                                 oldest_verdict.value, i_out_item.value);
                    end
                    if (i_out_item.is_prime !== oldest_verdict.is_prime) begin
                        o_fail_count++;
                        $display("%0t: is_prime for %0d expected %b, got %b", $time,
                                 oldest_verdict.value, oldest_verdict.is_prime,
                                 i_out_item.is_prime);
                    end
                    if (i_out_item.last_out !== oldest_verdict.last_out) begin
                        o_fail_count++;
                        $display("%0t: last_out for %0d expected %b, got %b", $time,
                                 oldest_verdict.value, oldest_verdict.last_out,
                                 i_out_item.last_out);
                    end
                end
            end
        end
        o_pending = expected_verdicts.size();
    end

endmodule

>>> tb/trial_division_prime_test_tb.sv
`timescale 1ns / 1ps

// Top of the prime tester bench. This module only produces stimulus and
// gives the verdict; all prediction and comparison happens in the checker
// that sits beside the block and watches the same wires.
module trial_division_prime_test_tb;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    tdpt_pkg::t_in_item  in_item = '0;
    logic                out_stall = 1'b0;
    logic                in_stall;
    logic                out_valid;
    tdpt_pkg::t_out_item out_item;

    int fail_count;
    int pending;
    int results_seen;
    int primes_seen;

    // Idling odds, in percent, for the sender and the receiver. The
    // stimulus process changes them from phase to phase.
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    // A nonzero value asks the receiver process to hold off for that many
    // cycles; the receiver clears it once it has taken the request.
    int long_hold_cycles = 0;
    int items_sent = 0;

    // Directed candidates: zero and one, two as the only even prime, small
    // odd primes, squares of primes where the divisor scan ends exactly at
    // the root, larger primes that need many trials, and wide values whose
    // upper bits are set but that a small divisor settles quickly.
    logic [31:0] directed_values [21] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15, 32'd25,
        32'd49, 32'd121, 32'd7919, 32'd65521, 32'd65535, 32'd1048573,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000, 32'h8000_0001,
        32'hFFFF_FFFE, 32'hFFFF_FFFF
    };

    always #5 i_clk = ~i_clk;

    trial_division_prime_test dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    trial_division_prime_test_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results_seen),
        .o_primes     (primes_seen)
    );

    // Offers one candidate and returns on the edge that accepts it. Idle
    // cycles before the offer keep valid low; once valid rises it stays up
    // with a fixed payload until the block takes the item.
    task automatic offer_candidate(input logic [31:0] candidate, input logic last);
        tdpt_pkg::t_in_item item;
        item.candidate = candidate;
        item.last_in = last;
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= item;
        do @(posedge i_clk); while (in_stall);
        items_sent++;
    endtask

    // Random candidates are kept mostly small, because an odd candidate
    // costs about a divider pass per trial up to its square root. Full
    // width values are made even or divisible by three so that their upper
    // bits get exercised while a small divisor ends the scan. Products of nearby
    // odd numbers push the scan right up to its stopping point.
    function automatic logic [31:0] random_candidate();
        int unsigned pick;
        int unsigned root;
        logic [31:0] wide;
        pick = $urandom_range(99);
        wide = $urandom;
        root = $urandom_range(255, 3) | 1;
        if (pick < 55) return $urandom_range(65535);
        if (pick < 65) return $urandom_range(32'h0010_0000, 32'h0001_0000);
        if (pick < 80) return wide & ~32'd1;
        if (pick < 90) return wide - (wide % 3);
        return $urandom_range(1) ? root * root : root * (root + 2);
    endfunction

    // Receiver side. A long hold request takes priority over the random
    // stalls and is counted down here, one cycle at a time.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_cycles != 0) begin
                hold_left = long_hold_cycles;
                long_hold_cycles = 0;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < receiver_stall_pct);
            end
        end
    end

    initial begin
        int phase;
        int idx;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed candidates go in back to back, with the last marker
        // alternating so that both of its values appear.
        idx = 0;
        foreach (directed_values[k]) begin
            offer_candidate(directed_values[k], idx[0]);
            idx++;
        end

        // The receiver holds off for a long stretch while the sender keeps
        // offering cheap candidates: the output register and the finished
        // candidate behind it fill, and the block must stall its input.
        long_hold_cycles = 3000;
        repeat (12) offer_candidate($urandom_range(999), $urandom_range(1));

        // Four idling mixes: none, a mostly idle sender, a mostly stalled
        // receiver, and light idling on both sides.
        for (phase = 0; phase < 4; phase++) begin
            sender_idle_pct = (phase == 1) ? 88 : (phase == 3) ? 14 : 0;
            receiver_stall_pct = (phase == 2) ? 88 : (phase == 3) ? 14 : 0;
            repeat (28) offer_candidate(random_candidate(), $urandom_range(1));
        end
        in_valid <= 1'b0;

        // Wait for every predicted result, then a short tail in which any
        // spurious extra result would still be caught.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("Tested %0d candidates (%0d reported prime): directed extremes,",
                 items_sent, primes_seen);
        $display("a long output hold, and four sender/receiver idling mixes.");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: a time limit well beyond the slowest legal run.
    initial begin
        #(64'd100_000_000);
        $display("Timeout with %0d results still outstanding.", pending);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
